// File: design/rigid_body_euler_step_defines.svh
// assertion macros used by the rigid body euler step sequencer
`ifndef RIGID_BODY_EULER_STEP_DEFINES_SVH
`define RIGID_BODY_EULER_STEP_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define RBE_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define RBE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/rbe_pkg.sv
// types, constants and microcode program of the rigid body euler step
package rbe_pkg;

    typedef logic signed [31:0] rbe_q_t;

    localparam rbe_q_t TWO_PI_Q16 = 32'sd411775;
    localparam rbe_q_t Q_MAX      = 32'sh7fff_ffff;
    localparam rbe_q_t Q_MIN      = 32'sh8000_0000;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ENTRY_STEP = 4'd0;
    localparam logic [ADDR_W-1:0] ENTRY_LOAD = 4'd8;

    typedef enum logic [1:0] {
        CMD_STEP,
        CMD_LOAD_POS,
        CMD_LOAD_VEL,
        CMD_LOAD_ANGLE
    } rbe_cmd_t;

    typedef enum logic [1:0] {
        CFG_TIME_STEP,
        CFG_INVERSE_MASS,
        CFG_ANGULAR_ACCEL
    } rbe_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } rbe_state_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MAC,
        OP_LOAD
    } rbe_op_t;

    typedef enum logic [2:0] {
        SRC_FORCE_X,
        SRC_FORCE_Y,
        SRC_VEL_X,
        SRC_VEL_Y,
        SRC_ACC_X,
        SRC_ACC_Y,
        SRC_SPIN,
        SRC_ANG_ACCEL
    } rbe_src_a_t;

    typedef enum logic {
        SRCB_INV_MASS,
        SRCB_TIME_STEP
    } rbe_src_b_t;

    typedef enum logic [2:0] {
        DST_ACC_X,
        DST_ACC_Y,
        DST_POS_X,
        DST_VEL_X,
        DST_POS_Y,
        DST_VEL_Y,
        DST_HEADING,
        DST_SPIN
    } rbe_dst_t;

    typedef struct packed {
        rbe_op_t    op;
        rbe_src_a_t src_a;
        rbe_src_b_t src_b;
        rbe_dst_t   dst;
        logic       accum;
        logic       wrap;
        logic       last;
    } rbe_uword_t;

    // sequencer to datapath control
    typedef struct packed {
        logic       start;
        logic       issue;
        rbe_uword_t uw;
    } rbe_ctl_t;

    typedef struct packed {
        rbe_q_t pos_x;
        rbe_q_t pos_y;
        rbe_q_t vel_x;
        rbe_q_t vel_y;
        rbe_q_t angle;
        rbe_q_t angular_vel;
        rbe_q_t accel_x;
        rbe_q_t accel_y;
        logic   saturated;
    } rbe_result_t;

    function automatic rbe_uword_t mac_word(rbe_src_a_t a, rbe_src_b_t b, rbe_dst_t d,
                                            logic acc, logic wrp, logic lst);
        rbe_uword_t w;
        w.op    = OP_MAC;
        w.src_a = a;
        w.src_b = b;
        w.dst   = d;
        w.accum = acc;
        w.wrap  = wrp;
        w.last  = lst;
        return w;
    endfunction

    // control store: the step program, then the load word
    function automatic rbe_uword_t rbe_rom(logic [ADDR_W-1:0] addr);
        rbe_uword_t w;
        w = '{op: OP_NOP, src_a: SRC_FORCE_X, src_b: SRCB_INV_MASS, dst: DST_ACC_X,
              accum: 1'b0, wrap: 1'b0, last: 1'b1};
        unique case (addr)
            4'd0:    w = mac_word(SRC_FORCE_X, SRCB_INV_MASS, DST_ACC_X, 1'b0, 1'b0, 1'b0);
            4'd1:    w = mac_word(SRC_FORCE_Y, SRCB_INV_MASS, DST_ACC_Y, 1'b0, 1'b0, 1'b0);
            4'd2:    w = mac_word(SRC_VEL_X, SRCB_TIME_STEP, DST_POS_X, 1'b1, 1'b0, 1'b0);
            4'd3:    w = mac_word(SRC_ACC_X, SRCB_TIME_STEP, DST_VEL_X, 1'b1, 1'b0, 1'b0);
            4'd4:    w = mac_word(SRC_VEL_Y, SRCB_TIME_STEP, DST_POS_Y, 1'b1, 1'b0, 1'b0);
            4'd5:    w = mac_word(SRC_ACC_Y, SRCB_TIME_STEP, DST_VEL_Y, 1'b1, 1'b0, 1'b0);
            4'd6:    w = mac_word(SRC_SPIN, SRCB_TIME_STEP, DST_HEADING, 1'b1, 1'b1, 1'b0);
            4'd7:    w = mac_word(SRC_ANG_ACCEL, SRCB_TIME_STEP, DST_SPIN, 1'b1, 1'b0, 1'b1);
            4'd8:    w.op = OP_LOAD;
            default: w.op = OP_NOP;
        endcase
        return w;
    endfunction

endpackage

// File: design/rbe_sequencer.sv
// step counter, dispatch and handshake control for the euler step
`include "rigid_body_euler_step_defines.svh"

module rbe_sequencer
    import rbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic [1:0] command,
    input  logic     out_free,
    output logic     in_stall,
    output logic     load_out,
    output rbe_ctl_t ctl
);

    rbe_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    rbe_uword_t        uw;

    assign uw = rbe_rom(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= ENTRY_STEP;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_stall   = 1'b1;
        load_out   = 1'b0;
        ctl.start  = 1'b0;
        ctl.issue  = 1'b0;
        ctl.uw     = uw;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    step_next  = (rbe_cmd_t'(command) == CMD_STEP) ? ENTRY_STEP : ENTRY_LOAD;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.issue = 1'b1;
                if (uw.last)
                    state_next = ST_FLUSH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RBE_ASSERT_NEXT(a_start_runs, ctl.start, state_reg == ST_RUN, "accepted word did not start the program")
    `RBE_ASSERT_NEXT(a_last_flushes, ctl.issue && uw.last, state_reg == ST_FLUSH, "last step did not flush")
    `RBE_ASSERT_NOW(a_load_out_free, load_out, out_free && state_reg == ST_DONE, "result loaded while output busy")

endmodule

// File: design/rbe_datapath.sv
// body state registers, shared multiplier and saturating accumulate stage
module rbe_datapath
    import rbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rbe_ctl_t    ctl,
    input  logic [1:0]  command,
    input  rbe_q_t      arg_x,
    input  rbe_q_t      arg_y,
    input  logic [16:0] time_step,
    input  logic [30:0] inverse_mass,
    input  rbe_q_t      angular_accel,
    output rbe_result_t result
);

    typedef struct packed {
        logic     valid;
        rbe_dst_t dst;
        logic     accum;
        logic     wrap;
    } wb_ctl_t;

    rbe_cmd_t cmd_reg;
    rbe_q_t   arg_x_reg, arg_y_reg;
    rbe_q_t   pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    rbe_q_t   heading_reg, spin_reg, acc_x_reg, acc_y_reg;
    logic     sat_reg;

    logic signed [64:0] prod_reg, prod_next;
    wb_ctl_t            wb_reg, wb_next;

    rbe_q_t             op_a;
    logic [31:0]        op_b;
    logic signed [48:0] q_full;
    logic               q_ovf;
    rbe_q_t             q_clamp;
    rbe_q_t             dst_val;
    logic signed [32:0] sum;
    logic               s_ovf;
    rbe_q_t             s_clamp;
    rbe_q_t             res_pre;
    rbe_q_t             res;

    // operand selection and multiply
    always_comb
    begin
        case (ctl.uw.src_a)
            SRC_FORCE_X:   op_a = arg_x_reg;
            SRC_FORCE_Y:   op_a = arg_y_reg;
            SRC_VEL_X:     op_a = vel_x_reg;
            SRC_VEL_Y:     op_a = vel_y_reg;
            SRC_ACC_X:     op_a = acc_x_reg;
            SRC_ACC_Y:     op_a = acc_y_reg;
            SRC_SPIN:      op_a = spin_reg;
            SRC_ANG_ACCEL: op_a = angular_accel;
            default:       op_a = '0;
        endcase
        case (ctl.uw.src_b)
            SRCB_INV_MASS:  op_b = {1'b0, inverse_mass};
            SRCB_TIME_STEP: op_b = {15'd0, time_step};
            default:        op_b = '0;
        endcase
    end

    assign prod_next = $signed({op_a[31], op_a}) * $signed({1'b0, op_b});

    always_comb
    begin
        wb_next.valid = ctl.issue && (ctl.uw.op == OP_MAC);
        wb_next.dst   = ctl.uw.dst;
        wb_next.accum = ctl.uw.accum;
        wb_next.wrap  = ctl.uw.wrap;
    end

    // floor by 2^16, clamp, saturating add, angle wrap
    assign q_full  = prod_reg[64:16];
    assign q_ovf   = (q_full[48:31] != {18{q_full[48]}});
    assign q_clamp = q_ovf ? (q_full[48] ? Q_MIN : Q_MAX) : q_full[31:0];

    always_comb
    begin
        case (wb_reg.dst)
            DST_ACC_X:   dst_val = acc_x_reg;
            DST_ACC_Y:   dst_val = acc_y_reg;
            DST_POS_X:   dst_val = pos_x_reg;
            DST_VEL_X:   dst_val = vel_x_reg;
            DST_POS_Y:   dst_val = pos_y_reg;
            DST_VEL_Y:   dst_val = vel_y_reg;
            DST_HEADING: dst_val = heading_reg;
            DST_SPIN:    dst_val = spin_reg;
            default:     dst_val = '0;
        endcase
    end

    assign sum     = {dst_val[31], dst_val} + {q_clamp[31], q_clamp};
    assign s_ovf   = (sum[32] != sum[31]);
    assign s_clamp = s_ovf ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
    assign res_pre = wb_reg.accum ? s_clamp : q_clamp;

    always_comb
    begin
        res = res_pre;
        if (wb_reg.wrap && (res_pre > TWO_PI_Q16))
            res = res_pre - TWO_PI_Q16;
        else if (wb_reg.wrap && (res_pre < -TWO_PI_Q16))
            res = res_pre + TWO_PI_Q16;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl.start)
        begin
            cmd_reg   <= rbe_cmd_t'(command);
            arg_x_reg <= arg_x;
            arg_y_reg <= arg_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg      <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            heading_reg <= '0;
            spin_reg    <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            wb_reg <= wb_next;
            if (ctl.start)
            begin
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (wb_reg.valid)
            begin
                sat_reg <= sat_reg | q_ovf | (wb_reg.accum & s_ovf);
                case (wb_reg.dst)
                    DST_ACC_X:   acc_x_reg   <= res;
                    DST_ACC_Y:   acc_y_reg   <= res;
                    DST_POS_X:   pos_x_reg   <= res;
                    DST_VEL_X:   vel_x_reg   <= res;
                    DST_POS_Y:   pos_y_reg   <= res;
                    DST_VEL_Y:   vel_y_reg   <= res;
                    DST_HEADING: heading_reg <= res;
                    DST_SPIN:    spin_reg    <= res;
                    default:     ;
                endcase
            end
            else if (ctl.issue && (ctl.uw.op == OP_LOAD))
            begin
                case (cmd_reg)
                    CMD_LOAD_POS:
                    begin
                        pos_x_reg <= arg_x_reg;
                        pos_y_reg <= arg_y_reg;
                    end
                    CMD_LOAD_VEL:
                    begin
                        vel_x_reg <= arg_x_reg;
                        vel_y_reg <= arg_y_reg;
                    end
                    CMD_LOAD_ANGLE:
                    begin
                        heading_reg <= arg_x_reg;
                        spin_reg    <= arg_y_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        result.pos_x       = pos_x_reg;
        result.pos_y       = pos_y_reg;
        result.vel_x       = vel_x_reg;
        result.vel_y       = vel_y_reg;
        result.angle       = heading_reg;
        result.angular_vel = spin_reg;
        result.accel_x     = acc_x_reg;
        result.accel_y     = acc_y_reg;
        result.saturated   = sat_reg;
    end

endmodule

// File: design/rigid_body_euler_step.sv
// top level of the 2d rigid body explicit euler integrator
//
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | command, arg_x, arg_y
//  out     | out_valid / out_stall  | pos, vel, angle, angular_vel, accel, sat
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  a step word runs from its accept cycle through eight microcode steps that
//  share one 33x33 multiplier, a flush state that drains the accumulate stage
//  and a done state that loads the output register; load words run the load
//  word in place of the steps. the output register lets a new word in while a
//  result waits, and a stalled output holds the sequencer only at its end
//  asynchronous active-low reset clears the body state and restores config
module rigid_body_euler_step
    import rbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] arg_x,
    input  logic signed [31:0] arg_y,
    // result words
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] angle,
    output logic signed [31:0] angular_vel,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic               saturated,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // configuration registers
    logic [16:0] time_step_reg;
    logic [30:0] inverse_mass_reg;
    rbe_q_t      angular_accel_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    rbe_result_t out_word_reg;

    rbe_ctl_t    ctl;
    rbe_result_t result;
    logic        load_out;
    logic        out_free;

    // writes are always taken; software must only write while the block is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= 17'd1092;
            inverse_mass_reg  <= 31'd65536;
            angular_accel_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rbe_cfg_idx_t'(cfg_index))
                CFG_TIME_STEP:     time_step_reg     <= cfg_data[16:0];
                CFG_INVERSE_MASS:  inverse_mass_reg  <= cfg_data[30:0];
                CFG_ANGULAR_ACCEL: angular_accel_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    rbe_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .out_free (out_free),
        .in_stall (in_stall),
        .load_out (load_out),
        .ctl      (ctl)
    );

    rbe_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .command       (command),
        .arg_x         (arg_x),
        .arg_y         (arg_y),
        .time_step     (time_step_reg),
        .inverse_mass  (inverse_mass_reg),
        .angular_accel (angular_accel_reg),
        .result        (result)
    );

    // valid rises on a load, falls once taken with nothing new behind it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // snapshot of the body state after the word
    always_ff @(posedge clk)
    begin
        if (load_out)
            out_word_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = out_word_reg.pos_x;
    assign pos_y       = out_word_reg.pos_y;
    assign vel_x       = out_word_reg.vel_x;
    assign vel_y       = out_word_reg.vel_y;
    assign angle       = out_word_reg.angle;
    assign angular_vel = out_word_reg.angular_vel;
    assign accel_x     = out_word_reg.accel_x;
    assign accel_y     = out_word_reg.accel_y;
    assign saturated   = out_word_reg.saturated;

endmodule
